// File: src/idu_pkg.sv
// ----------------------------------------------------------------------------
// idu_pkg
// Shared types and constants for the shift-subtract integer divider.
// ----------------------------------------------------------------------------
package idu_pkg;

  localparam int unsigned Width = 32;
  localparam int unsigned CntW  = $clog2(Width);

  typedef enum logic {
    OP_UNSIGNED = 1'b0,
    OP_SIGNED   = 1'b1
  } op_e;

  typedef struct packed {
    logic             operation;
    logic [Width-1:0] dividend;
    logic [Width-1:0] divisor;
  } in_item_t;

  typedef struct packed {
    logic [Width-1:0] quotient;
    logic [Width-1:0] remainder;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } dp_cmd_t;

endpackage

// File: src/idu_ctrl.sv
// ----------------------------------------------------------------------------
// idu_ctrl
// Sequencer for the divider: accepts an item, counts the quotient bits and
// hands the finished result to the output register.
// ----------------------------------------------------------------------------
module idu_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output idu_pkg::dp_cmd_t cmd_o
);
  import idu_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_FIX  = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            last_bit;

  assign last_bit = (cnt_q == CntW'(Width - 1));

  always_comb begin
    cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.step   = (state_q == ST_CALC);
    // output register free or being emptied this cycle
    cmd_o.finish = (state_q == ST_FIX) && (!out_valid_q || !out_stall_i);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CALC;
          cnt_d   = '0;
        end
      end
      ST_CALC: begin
        cnt_d = cnt_q + 1'b1;
        if (last_bit) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        if (cmd_o.finish) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: src/idu_datapath.sv
// ----------------------------------------------------------------------------
// idu_datapath
// Operand magnitudes, restoring shift-subtract step and sign fix-up, with
// the output result register.
// ----------------------------------------------------------------------------
module idu_datapath (
  input  logic               clk_i,
  input  idu_pkg::dp_cmd_t   cmd_i,
  input  idu_pkg::in_item_t  in_item_i,
  output idu_pkg::out_item_t out_item_o
);
  import idu_pkg::*;

  logic [Width-1:0] quo_q, quo_d;
  logic [Width-1:0] rem_q, rem_d;
  logic [Width-1:0] dvs_q, dvs_d;
  logic             negq_q, negq_d;
  logic             negr_q, negr_d;
  logic             dzero_q, dzero_d;
  out_item_t        res_q, res_d;

  logic             is_signed, nneg, dneg;
  logic [Width:0]   shifted;
  logic [Width+1:0] diff;
  logic             take;

  assign is_signed = (in_item_i.operation == OP_SIGNED);
  assign nneg      = is_signed && in_item_i.dividend[Width-1];
  assign dneg      = is_signed && in_item_i.divisor[Width-1];

  // partial remainder gets one extra bit so the compare never overflows
  assign shifted = {rem_q, quo_q[Width-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign take    = !diff[Width+1];

  always_comb begin
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    negq_d  = negq_q;
    negr_d  = negr_q;
    dzero_d = dzero_q;
    res_d   = res_q;
    if (cmd_i.load) begin
      quo_d   = nneg ? (Width'(0) - in_item_i.dividend) : in_item_i.dividend;
      dvs_d   = dneg ? (Width'(0) - in_item_i.divisor) : in_item_i.divisor;
      rem_d   = '0;
      negq_d  = nneg ^ dneg;
      negr_d  = nneg;
      dzero_d = (in_item_i.divisor == '0);
    end else if (cmd_i.step) begin
      // dividend bits shift out the top as quotient bits shift in
      quo_d = {quo_q[Width-2:0], take};
      rem_d = take ? diff[Width-1:0] : shifted[Width-1:0];
    end
    if (cmd_i.finish) begin
      // zero divisor leaves the dividend in the remainder already
      if (dzero_q) begin
        res_d.quotient = '0;
      end else begin
        res_d.quotient = negq_q ? (Width'(0) - quo_q) : quo_q;
      end
      res_d.remainder = negr_q ? (Width'(0) - rem_q) : rem_q;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    dvs_q   <= dvs_d;
    negq_q  <= negq_d;
    negr_q  <= negr_d;
    dzero_q <= dzero_d;
    res_q   <= res_d;
  end

  assign out_item_o = res_q;

endmodule

// File: src/integer_divider_signed_unsigned_unit.sv
// ----------------------------------------------------------------------------
// integer_divider_signed_unsigned_unit
// Signed or unsigned 32-bit divider returning quotient and remainder.
// ----------------------------------------------------------------------------
// an item goes through load, shift-subtract steps and sign fix-up into the output register;
//   the fix-up waits while a stalled result still occupies that register
// one quotient bit per cycle (load, 32 steps, sign fix-up); an item is taken only when idle
// the next item is accepted while a finished result waits in the output register
// reset clears the controller and the output valid; no memories, no clearing pass
module integer_divider_signed_unsigned_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  idu_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output idu_pkg::out_item_t out_item_o
);
  import idu_pkg::*;

  dp_cmd_t cmd;

  idu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  idu_datapath u_datapath (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

endmodule

// File: src/idu_checker.sv
// ----------------------------------------------------------------------------
// idu_checker
// Port-level checks on the divider: result hold, busy after accept and
// result arrival after an accept into an empty block.
// ----------------------------------------------------------------------------
module idu_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input idu_pkg::out_item_t out_item_o
);
  import idu_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // one item at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input taken while an item is in flight");

  // no result appears right after an item enters an empty block
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !out_valid_o |-> ##34 out_valid_o)
    else $error("result missing after fixed latency");

endmodule

bind integer_divider_signed_unsigned_unit idu_checker u_idu_checker (.*);
